// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro names its label and the condition to hold on every rising clock edge outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked at every rising edge outside reset.
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Implication checked at every rising edge outside reset.
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/cbr_pkg.sv =====
// Package for the block receiver: codes, the beat struct passed from front to back, CRC helper.
// No dependencies.
`timescale 1ns / 1ps
package cbr_pkg;
  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;
  // Unused action code; the receiver ignores it.
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam logic [2:0] K_PAYLOAD = 3'd0;
  localparam logic [2:0] K_ACK     = 3'd1;
  localparam logic [2:0] K_NAK     = 3'd2;
  localparam logic [2:0] K_DONE    = 3'd3;
  localparam logic [2:0] K_ERROR   = 3'd4;
  localparam logic [1:0] E_BAD_BLOCK = 2'd0;
  localparam logic [1:0] E_TIMEOUT   = 2'd1;
  localparam logic [1:0] E_XFER_CRC  = 2'd2;
  localparam logic [1:0] CFG_XFER_SIZE = 2'd0;
  localparam logic [1:0] CFG_XFER_CRC  = 2'd1;
  localparam logic [1:0] CFG_MAX_BLOCK = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT   = 2'd3;
  localparam logic [3:0] HDR_BYTES = 4'd14;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  // One result beat.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic [31:0] sequence_res;
    logic [31:0] byte_count;
    logic [31:0] crc_value;
    logic [1:0]  error_code;
    logic        last;
  } res_t;

  // Up to three results caused by one input, packed for the queue.
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
    res_t       r2;
  } grp_t;

  // Bytewise reflected CRC-32 on finished values.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return ~c;
  endfunction
endpackage

// ===== rtl/cbr_front.sv =====
// Front part: protocol state, header checks, CRC tracking; produces a result group per input.
// Depends on cbr_pkg.
`timescale 1ns / 1ps
module cbr_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      action,
  input  logic [7:0]      data_byte,
  output logic            grp_valid,
  input  logic            grp_ready,
  output cbr_pkg::grp_t   grp
);
  import cbr_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_PAYLOAD} phase_t;

  logic [31:0] xfer_size, xfer_crc;
  logic [15:0] max_block_bytes;
  logic [19:0] timeout_ticks;
  phase_t      phase;
  logic [3:0]  header_index;
  logic        magic_ok;
  logic [31:0] block_seq, block_crc_expected, block_crc_running;
  logic [15:0] block_len, payload_index;
  logic [31:0] file_crc_tentative, file_crc_committed, expected_seq, committed_bytes;
  logic [19:0] phase_ticks;

  assign cfg_ready = 1'b1;
  assign in_ready  = grp_ready;
  assign grp_valid = in_valid;

  // Next-state and result computation for one input.
  phase_t      phase_next;
  logic [3:0]  header_index_next;
  logic        magic_ok_next;
  logic [31:0] block_seq_next, block_crc_expected_next, block_crc_running_next;
  logic [15:0] block_len_next, payload_index_next;
  logic [31:0] ftent_next, fcom_next, expected_seq_next, committed_next;
  logic [19:0] phase_ticks_next;
  logic [31:0] bcrc_new, fcrc_new, remaining, sum_bytes;
  logic [7:0]  magic_byte;
  logic [19:0] tick_inc;
  res_t        rs [3];
  logic [1:0]  n;

  always_comb begin
    case (header_index[1:0])
      2'd0: magic_byte = 8'h48;
      2'd1: magic_byte = 8'h4C;
      2'd2: magic_byte = 8'h56;
      default: magic_byte = 8'h42;
    endcase
  end

  assign bcrc_new  = crc_byte(block_crc_running, data_byte);
  assign fcrc_new  = crc_byte(file_crc_tentative, data_byte);
  assign remaining = (committed_bytes < xfer_size) ? xfer_size - committed_bytes : 32'd0;
  assign sum_bytes = committed_bytes + {16'd0, block_len};
  assign tick_inc  = phase_ticks + 20'd1;

  always_comb begin
    phase_next = phase;
    header_index_next = header_index;
    magic_ok_next = magic_ok;
    block_seq_next = block_seq;
    block_len_next = block_len;
    block_crc_expected_next = block_crc_expected;
    block_crc_running_next = block_crc_running;
    payload_index_next = payload_index;
    ftent_next = file_crc_tentative;
    fcom_next = file_crc_committed;
    expected_seq_next = expected_seq;
    committed_next = committed_bytes;
    phase_ticks_next = phase_ticks;
    n = 2'd0;
    for (int k = 0; k < 3; k++) rs[k] = '0;
    case (action)
      ACT_START: begin
        expected_seq_next = '0;
        committed_next = '0;
        fcom_next = '0;
        ftent_next = '0;
        block_crc_running_next = '0;
        payload_index_next = '0;
        phase_next = PH_HEADER;
        header_index_next = '0;
        magic_ok_next = 1'b1;
        block_seq_next = '0;
        block_len_next = '0;
        block_crc_expected_next = '0;
        phase_ticks_next = '0;
        if (xfer_size == 32'd0) begin
          rs[0].crc_value = 32'd0;
          if (xfer_crc == 32'd0) begin
            rs[0].kind = K_DONE;
            rs[0].byte_count = xfer_size;
          end else begin
            rs[0].kind = K_ERROR;
            rs[0].error_code = E_XFER_CRC;
          end
          n = 2'd1;
          phase_next = PH_IDLE;
        end
      end
      ACT_TICK: begin
        if (phase != PH_IDLE) begin
          phase_ticks_next = tick_inc;
          if (tick_inc >= timeout_ticks) begin
            rs[0].kind = K_ERROR;
            rs[0].error_code = E_TIMEOUT;
            n = 2'd1;
            phase_next = PH_IDLE;
            phase_ticks_next = '0;
          end
        end
      end
      ACT_BYTE: begin
        if (phase == PH_HEADER) begin
          if (header_index < 4'd4) begin
            if (data_byte != magic_byte) magic_ok_next = 1'b0;
          end else if (header_index < 4'd8) begin
            block_seq_next = block_seq | ({24'd0, data_byte} << {header_index[1:0], 3'd0});
          end else if (header_index < 4'd10) begin
            block_len_next = block_len | ({8'd0, data_byte} << {header_index[0], 3'd0});
          end else if (header_index < HDR_BYTES) begin
            block_crc_expected_next = block_crc_expected
                | ({24'd0, data_byte} << {header_index[1:0] - 2'd2, 3'd0});
          end
          header_index_next = header_index + 4'd1;
          if (header_index_next >= HDR_BYTES) begin
            if (!magic_ok_next || block_seq_next != expected_seq ||
                block_len_next == 16'd0 || block_len_next > max_block_bytes ||
                {16'd0, block_len_next} > remaining) begin
              rs[0].kind = K_ERROR;
              rs[0].error_code = E_BAD_BLOCK;
              n = 2'd1;
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_PAYLOAD;
              payload_index_next = '0;
              block_crc_running_next = '0;
              ftent_next = file_crc_committed;
              phase_ticks_next = '0;
            end
          end
        end else if (phase == PH_PAYLOAD) begin
          rs[0].kind = K_PAYLOAD;
          rs[0].payload_byte = data_byte;
          n = 2'd1;
          block_crc_running_next = bcrc_new;
          ftent_next = fcrc_new;
          payload_index_next = payload_index + 16'd1;
          if (payload_index_next == block_len) begin
            rs[1].sequence_res = expected_seq;
            n = 2'd2;
            if (bcrc_new == block_crc_expected) begin
              committed_next = sum_bytes;
              fcom_next = fcrc_new;
              rs[1].kind = K_ACK;
              rs[1].byte_count = sum_bytes;
              expected_seq_next = expected_seq + 32'd1;
            end else begin
              rs[1].kind = K_NAK;
              rs[1].byte_count = committed_bytes;
            end
            phase_next = PH_HEADER;
            header_index_next = '0;
            magic_ok_next = 1'b1;
            block_seq_next = '0;
            block_len_next = '0;
            block_crc_expected_next = '0;
            phase_ticks_next = '0;
            if (bcrc_new == block_crc_expected && sum_bytes >= xfer_size) begin
              rs[2].crc_value = fcrc_new;
              if (fcrc_new == xfer_crc) begin
                rs[2].kind = K_DONE;
                rs[2].byte_count = xfer_size;
              end else begin
                rs[2].kind = K_ERROR;
                rs[2].error_code = E_XFER_CRC;
              end
              n = 2'd3;
              phase_next = PH_IDLE;
            end
          end
        end
      end
      default: ;
    endcase
    if (n != 2'd0) rs[n - 2'd1].last = 1'b1;
  end

  assign grp.count = n;
  assign grp.r0 = rs[0];
  assign grp.r1 = rs[1];
  assign grp.r2 = rs[2];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      xfer_size <= 32'd1;
      xfer_crc <= '0;
      max_block_bytes <= 16'd1024;
      timeout_ticks <= 20'd10000;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_XFER_SIZE: xfer_size <= cfg_data;
        CFG_XFER_CRC:  xfer_crc <= cfg_data;
        CFG_MAX_BLOCK: max_block_bytes <= cfg_data[15:0];
        CFG_TIMEOUT:   timeout_ticks <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // Protocol state advances on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      header_index <= '0;
      magic_ok <= 1'b1;
      block_seq <= '0;
      block_len <= '0;
      block_crc_expected <= '0;
      payload_index <= '0;
      block_crc_running <= '0;
      file_crc_tentative <= '0;
      file_crc_committed <= '0;
      expected_seq <= '0;
      committed_bytes <= '0;
      phase_ticks <= '0;
    end else if (in_valid && in_ready) begin
      phase <= phase_next;
      header_index <= header_index_next;
      magic_ok <= magic_ok_next;
      block_seq <= block_seq_next;
      block_len <= block_len_next;
      block_crc_expected <= block_crc_expected_next;
      payload_index <= payload_index_next;
      block_crc_running <= block_crc_running_next;
      file_crc_tentative <= ftent_next;
      file_crc_committed <= fcom_next;
      expected_seq <= expected_seq_next;
      committed_bytes <= committed_next;
      phase_ticks <= phase_ticks_next;
    end
  end
endmodule

// ===== rtl/cbr_queue.sv =====
// Two-entry queue of result groups between front and back.
// Depends on cbr_pkg.
`timescale 1ns / 1ps
module cbr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  cbr_pkg::grp_t wr_grp,
  output logic          rd_valid,
  input  logic          rd_ready,
  output cbr_pkg::grp_t rd_grp
);
  import cbr_pkg::*;

  grp_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic       push, pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_grp   = slots[rd_ptr];
  // Groups with no result are dropped at the door.
  assign push = wr_valid && wr_ready && (wr_grp.count != 2'd0);
  assign pop  = rd_valid && rd_ready;

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_grp;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/cbr_back.sv =====
// Back part: plays out the results of each group one beat at a time.
// Depends on cbr_pkg.
`timescale 1ns / 1ps
module cbr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          grp_valid,
  output logic          grp_ready,
  input  cbr_pkg::grp_t grp,
  output logic          out_valid,
  input  logic          out_ready,
  output cbr_pkg::res_t res
);
  import cbr_pkg::*;

  logic [1:0] sel;
  logic       fire, at_end;

  always_comb begin
    case (sel)
      2'd0: res = grp.r0;
      2'd1: res = grp.r1;
      default: res = grp.r2;
    endcase
  end

  assign out_valid = grp_valid;
  assign fire      = out_valid && out_ready;
  assign at_end    = (sel + 2'd1 == grp.count);
  assign grp_ready = fire && at_end;

  // Result index within the current group.
  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= '0;
    end else if (fire) begin
      sel <= at_end ? 2'd0 : sel + 2'd1;
    end
  end
endmodule

// ===== rtl/crc_checked_block_receiver_core.sv =====
// Top level of the block receiver: front, result queue and back.
// Depends on cbr_pkg, cbr_front, cbr_queue and cbr_back.
`timescale 1ns / 1ps
// Usage:
// Input beats carry an action (stream byte, tick or start) and a data byte on
// in_valid/in_ready. Result beats leave on out_valid/out_ready with kind,
// payload byte, sequence, byte count, CRC, error code and a last flag on the
// final result of each input.
// Configuration writes on cfg_valid/cfg_ready are taken every cycle; write
// them only while the block is idle.
// Throughput: one input beat per cycle while each input yields at most one
// result and out_ready stays high; the results of an input that causes two or
// three leave one after another on the single output port. The bytewise CRC
// and header checks are done in the front in the cycle of acceptance.
// Results are registered in the queue when their input is accepted.
// Reset clears the protocol state to idle and loads the register defaults.
// When the receiver stalls, the two-group queue fills and then in_ready
// drops; no beat is lost.
module crc_checked_block_receiver_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [31:0] sequence_res,
  output logic [31:0] byte_count,
  output logic [31:0] crc_value,
  output logic [1:0]  error_code,
  output logic        last
);
  import cbr_pkg::*;

  grp_t fq_grp, qb_grp;
  logic fq_valid, fq_ready, qb_valid, qb_ready;
  res_t res;

  cbr_front u_front (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .action, .data_byte,
    .grp_valid(fq_valid), .grp_ready(fq_ready), .grp(fq_grp)
  );

  cbr_queue u_queue (
    .clk, .rst, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_grp(fq_grp),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_grp(qb_grp)
  );

  cbr_back u_back (
    .clk, .rst, .grp_valid(qb_valid), .grp_ready(qb_ready), .grp(qb_grp),
    .out_valid, .out_ready, .res
  );

  assign kind         = res.kind;
  assign payload_byte = res.payload_byte;
  assign sequence_res = res.sequence_res;
  assign byte_count   = res.byte_count;
  assign crc_value    = res.crc_value;
  assign error_code   = res.error_code;
  assign last         = res.last;
endmodule

// ===== rtl/cbr_checker.sv =====
// Port-level checker for the block receiver, bound to the top level.
// Depends on assert_macros.svh and cbr_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cbr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  kind,
  input logic [7:0]  payload_byte,
  input logic [1:0]  error_code,
  input logic        last
);
  import cbr_pkg::*;

  // A stalled result beat holds.
  `CHK_IMPL(a_out_hold, out_valid && !out_ready, out_valid && $stable({kind, last}), "beat moved")
  // Kind stays within its codes.
  `CHK_ALWAYS(a_kind_range, !out_valid || kind <= K_ERROR, "bad result kind")
  // Only error results carry an error code.
  `CHK_ALWAYS(a_err_code, !out_valid || kind == K_ERROR || error_code == E_BAD_BLOCK, "stray code")
  // A beat that is not last is a payload byte or an ack.
  `CHK_ALWAYS(a_nonlast, !out_valid || last || kind == K_PAYLOAD || kind == K_ACK, "bad non-final")
  // Only payload results carry a byte.
  `CHK_ALWAYS(a_pb_zero, !out_valid || kind == K_PAYLOAD || payload_byte == 8'd0, "stray byte")
endmodule

bind crc_checked_block_receiver_core cbr_checker u_checker (
  .clk, .rst, .out_valid, .out_ready, .kind, .payload_byte, .error_code, .last
);
